>>> hw/rtl/channel_freshness_watchdog_unit_macros.svh
// ----------------------------------------------------------------------------
// Channel freshness watchdog assertion macros
// Shared concurrent assertion forms for the watchdog RTL.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_FRESHNESS_WATCHDOG_UNIT_MACROS_SVH
`define CHANNEL_FRESHNESS_WATCHDOG_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CFW_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("watchdog assertion failed");

// Next-cycle implication, checked outside reset.
`define CFW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("watchdog assertion failed");

`endif

>>> hw/rtl/cfw_pkg.sv
// ----------------------------------------------------------------------------
// Channel freshness watchdog package
// Widths, codes and word types shared by the watchdog RTL.
// ----------------------------------------------------------------------------
package cfw_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int MASK_W       = 16;
    localparam int TIME_W       = 32;
    localparam int CNT_W        = 5;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;

    // Item modes.
    localparam logic [1:0] MODE_BEGIN   = 2'd0;
    localparam logic [1:0] MODE_RESET   = 2'd1;
    localparam logic [1:0] MODE_OBSERVE = 2'd2;
    localparam logic [1:0] MODE_EVAL    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [MASK_W-1:0] channel_mask;
        logic [TIME_W-1:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [MASK_W-1:0] enabled_out;
        logic [MASK_W-1:0] observed_out;
        logic [MASK_W-1:0] pending_out;
        logic              any_enabled;
        logic [MASK_W-1:0] stale_out;
        logic [CNT_W-1:0]  stale_num;
        logic [TIME_W-1:0] oldest_age;
        logic [TIME_W-1:0] update_age;
        logic [TIME_W-1:0] timeout_total;
        logic              all_fresh;
    } t_out_word;

endpackage

>>> hw/rtl/cfw_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cfw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/channel_freshness_watchdog_unit.sv
// Begin and reset words are done in S_IDLE; an observe word that hits an
// enabled channel walks N = min(CHANNELS, 16) entries, writing the stamp of each
// hit channel; an evaluate word reads them all, drains the last read, then waits
// in S_FIN for room in the result register. A new word is taken only in S_IDLE.
// Reset is synchronous; it clears control and window state, not the stamp memory.
// ----------------------------------------------------------------------------
// Channel freshness watchdog
// Tracks per-channel last-seen stamps in a small RAM and reports the oldest
// channel age, stale and pending masks and a running timeout count on evaluate words.
// ----------------------------------------------------------------------------
`include "channel_freshness_watchdog_unit_macros.svh"

module channel_freshness_watchdog_unit #(
    parameter int CHANNELS = cfw_pkg::CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [cfw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cfw_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  cfw_pkg::t_in_word                   i_in_word,
    // Output channel.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output cfw_pkg::t_out_word                  o_out_word
);

    // Only the channels that fit in the 16-bit masks are ever tracked.
    localparam int TRACKED = (CHANNELS < cfw_pkg::MASK_W) ? CHANNELS : cfw_pkg::MASK_W;
    localparam int IDX_W   = (TRACKED > 1) ? $clog2(TRACKED) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TRACKED - 1);

    localparam int MW = cfw_pkg::MASK_W;
    localparam int TW = cfw_pkg::TIME_W;
    localparam int CW = cfw_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OBS,
        S_EVAL,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [MW-1:0] r_cfg_en;
    logic [TW-1:0] r_cfg_timeout;

    // Architectural state outside the timestamp memory.
    logic [MW-1:0] r_observed;
    logic [MW-1:0] r_stale;
    logic [TW-1:0] r_wstart;
    logic [TW-1:0] r_last_upd;
    logic [TW-1:0] r_tcount;

    // Per-word working registers.
    logic [TW-1:0]    r_now;
    logic [MW-1:0]    r_rel;
    logic [IDX_W-1:0] r_idx;

    // Read-data stage of the evaluation walk.
    logic             r_pv;
    logic [IDX_W-1:0] r_pidx;
    logic [MW-1:0]    r_next;
    logic [CW-1:0]    r_scnt;
    logic [CW-1:0]    r_newcnt;
    logic [TW-1:0]    r_oldest;

    logic               r_out_vld;
    cfw_pkg::t_out_word r_out;

    logic [TW-1:0] ram_rdata;
    logic          ram_we;
    logic          ram_re;

    logic [MW-1:0] c_rel;
    logic [TW-1:0] c_ref;
    logic [TW-1:0] c_age;
    logic          c_hit;
    logic          c_stale;
    logic          c_out_space;
    logic [MW-1:0] c_obs;
    logic [MW-1:0] c_pend;
    logic          c_any;
    logic [TW-1:0] c_upd_base;

    // The last-seen memory holds no reset image. An entry is only consulted when
    // its observed bit is set, and that bit is only set together with a write of
    // the entry, so a restart of the window never needs to sweep the memory.
    cfw_ram #(
        .WIDTH (TW),
        .DEPTH (TRACKED)
    ) u_last_seen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_now),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // Writes happen only while walking an observe word and reads only while
    // walking an evaluate word; words are handled one at a time, so a read and
    // a write of the same entry never overlap.
    assign ram_we = (r_state == S_OBS) && r_rel[r_idx];
    assign ram_re = (r_state == S_EVAL);

    assign c_rel = i_in_word.channel_mask & r_cfg_en;

    // Age of the channel whose stamp is in the read register. An unobserved
    // channel ages from the window start.
    assign c_ref   = r_observed[r_pidx] ? ram_rdata : r_wstart;
    assign c_age   = r_now - c_ref;
    assign c_hit   = r_pv && r_cfg_en[r_pidx];
    assign c_stale = (r_cfg_timeout != '0) && (c_age >= r_cfg_timeout);

    assign c_out_space = !r_out_vld || i_out_ready;
    assign c_obs       = r_observed & r_cfg_en;
    assign c_pend      = r_cfg_en & ~c_obs;
    assign c_any       = (r_cfg_en != '0);
    // A last update time of zero reads as "no update seen".
    assign c_upd_base  = (r_last_upd == '0) ? r_wstart : r_last_upd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cfg_en      <= '0;
            r_cfg_timeout <= '0;
            r_observed    <= '0;
            r_stale       <= '0;
            r_wstart      <= '0;
            r_last_upd    <= '0;
            r_tcount      <= '0;
            r_idx         <= '0;
            r_pv          <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cfw_pkg::REG_ENABLED: r_cfg_en      <= i_cfg_data[MW-1:0];
                    cfw_pkg::REG_TIMEOUT: r_cfg_timeout <= i_cfg_data[TW-1:0];
                    default: ;
                endcase
            end

            // In S_FIN the result register is reloaded below instead.
            if (r_out_vld && i_out_ready && (r_state != S_FIN)) begin
                r_out_vld <= 1'b0;
            end

            // A read issued during the walk is folded in on the next cycle.
            r_pv <= (r_state == S_EVAL);

            // Fold one channel into the evaluation result.
            if (c_hit) begin
                if (c_age > r_oldest) begin
                    r_oldest <= c_age;
                end
                if (c_stale) begin
                    r_next[r_pidx] <= 1'b1;
                    r_scnt         <= r_scnt + CW'(1);
                    if (!r_stale[r_pidx]) begin
                        r_newcnt <= r_newcnt + CW'(1);
                    end
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_now <= i_in_word.now_ms;
                        r_idx <= '0;
                        unique case (i_in_word.mode)
                            cfw_pkg::MODE_BEGIN, cfw_pkg::MODE_RESET: begin
                                if (i_in_word.mode == cfw_pkg::MODE_BEGIN) begin
                                    r_tcount <= '0;
                                end
                                r_observed <= '0;
                                r_stale    <= '0;
                                r_wstart   <= i_in_word.now_ms;
                                r_last_upd <= '0;
                            end
                            cfw_pkg::MODE_OBSERVE: begin
                                // Masks and update time change at once; the
                                // stamps follow one channel per cycle.
                                if (c_rel != '0) begin
                                    r_observed <= r_observed | c_rel;
                                    r_stale    <= r_stale & ~c_rel;
                                    r_last_upd <= i_in_word.now_ms;
                                    r_rel      <= c_rel;
                                    r_state    <= S_OBS;
                                end
                            end
                            cfw_pkg::MODE_EVAL: begin
                                r_next   <= '0;
                                r_scnt   <= '0;
                                r_newcnt <= '0;
                                r_oldest <= '0;
                                r_state  <= S_EVAL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_OBS: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_EVAL: begin
                    r_pidx <= r_idx;
                    r_idx  <= r_idx + IDX_W'(1);
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // Hold here until the result register can take the word.
                    if (c_out_space) begin
                        r_out.enabled_out   <= r_cfg_en;
                        r_out.observed_out  <= c_obs;
                        r_out.pending_out   <= c_pend;
                        r_out.any_enabled   <= c_any;
                        r_out.stale_out     <= r_next;
                        r_out.stale_num     <= r_scnt;
                        r_out.oldest_age    <= r_oldest;
                        r_out.update_age    <= r_now - c_upd_base;
                        r_out.timeout_total <= r_tcount + TW'(r_newcnt);
                        r_out.all_fresh     <= c_any && (c_pend == '0) && (r_next == '0);
                        r_out_vld           <= 1'b1;
                        r_tcount            <= r_tcount + TW'(r_newcnt);
                        r_stale             <= r_next;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The incremental stale count must agree with the stale mask it reports.
    `CFW_ASSERT_IMPL(a_stale_count, i_clk, i_rst_n, r_out_vld,
        r_out.stale_num == CW'($countones(r_out.stale_out)))
    // A fresh report never carries a pending or stale channel.
    `CFW_ASSERT_IMPL(a_fresh_clean, i_clk, i_rst_n, r_out_vld && r_out.all_fresh,
        (r_out.stale_out == '0) && (r_out.pending_out == '0) && r_out.any_enabled)
    // Read data is only folded in while an evaluation walk is running.
    `CFW_ASSERT_IMPL(a_pv_in_eval, i_clk, i_rst_n, r_pv,
        (r_state == S_EVAL) || (r_state == S_DRAIN))
    // The last read of a walk is folded in before the result is formed.
    `CFW_ASSERT_NEXT(a_drain_fold, i_clk, i_rst_n, r_state == S_DRAIN,
        (r_state == S_FIN) && !r_pv)

endmodule
